// ===== src/line_pixel_stepper_defines.svh =====
// ----------------------------------------------------------------------------
// line_pixel_stepper_defines.svh
// Assertion macros used by the line pixel stepper RTL (lps_stepper).
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_STEPPER_DEFINES_SVH
`define LINE_PIXEL_STEPPER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Types and constants shared by the line pixel stepper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int STRIDE_W       = 8;
    localparam int SIZE_W         = 11;
    localparam int OFFSET_W       = 17;
    localparam int MASK_W         = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 11;

    // Request codes.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_STRIDE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_HEIGHT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOUNDS_ENABLE  = 2'd3;

    // Register reset values.
    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST     = 8'd128;
    localparam logic [SIZE_W-1:0]   SURFACE_WIDTH_RST  = 11'd1024;
    localparam logic [SIZE_W-1:0]   SURFACE_HEIGHT_RST = 11'd1024;
    localparam logic                BOUNDS_ENABLE_RST  = 1'b1;

    localparam logic [MASK_W-1:0] LEFT_PIXEL_MASK = 8'h80;

    typedef struct packed {
        logic has_result;
        logic last_pixel;
        logic rejected;
    } t_res_flags;

endpackage

`default_nettype wire

// ===== src/line_pixel_stepper.sv =====
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Bresenham line engine for a 1-bit-per-pixel frame buffer.
// ----------------------------------------------------------------------------
// One item per clock while the output side takes results: a start item loads
// a line or, if an endpoint fails the bounds check, returns a rejected result;
// each step item on an active line gives the next pixel, byte offset and bit
// mask. An item is registered in the input register, its result then in the
// output register; a stalled output register holds the input stage, which
// drops o_in_ready. Configuration is written through a plain write port; the
// user must do so only while the block idles; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_stepper #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lps_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [lps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_req_type,
    input  wire logic [COORD_BITS-1:0]            i_start_x,
    input  wire logic [COORD_BITS-1:0]            i_start_y,
    input  wire logic [COORD_BITS-1:0]            i_end_x,
    input  wire logic [COORD_BITS-1:0]            i_end_y,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [COORD_BITS-1:0]                 o_pixel_x,
    output logic [COORD_BITS-1:0]                 o_pixel_y,
    output logic [lps_pkg::OFFSET_W-1:0]          o_byte_offset,
    output logic [lps_pkg::MASK_W-1:0]            o_bit_mask,
    output logic                                  o_last_pixel,
    output logic                                  o_rejected
);
    import lps_pkg::*;

    logic [STRIDE_W-1:0]    r_row_stride;
    logic [SIZE_W-1:0]      r_surface_width;
    logic [SIZE_W-1:0]      r_surface_height;
    logic                   r_bounds_check_enable;

    logic                   r_s1_valid;
    logic                   r_s1_req_type;
    logic [COORD_BITS-1:0]  r_s1_start_x, r_s1_start_y, r_s1_end_x, r_s1_end_y;

    logic                   out_free;
    logic                   s1_fire;
    logic                   in_fire;

    logic [COORD_BITS-1:0]  res_pixel_x, res_pixel_y;
    logic [OFFSET_W-1:0]    res_byte_offset;
    logic [MASK_W-1:0]      res_bit_mask;
    t_res_flags             res_flags;

    logic                   r_out_valid;
    logic [COORD_BITS-1:0]  r_pixel_x, r_pixel_y;
    logic [OFFSET_W-1:0]    r_byte_offset;
    logic [MASK_W-1:0]      r_bit_mask;
    logic                   r_last_pixel, r_rejected;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_stride          <= ROW_STRIDE_RST;
            r_surface_width       <= SURFACE_WIDTH_RST;
            r_surface_height      <= SURFACE_HEIGHT_RST;
            r_bounds_check_enable <= BOUNDS_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_STRIDE:     r_row_stride          <= i_cfg_data[STRIDE_W-1:0];
                CFG_SURFACE_WIDTH:  r_surface_width       <= i_cfg_data[SIZE_W-1:0];
                CFG_SURFACE_HEIGHT: r_surface_height      <= i_cfg_data[SIZE_W-1:0];
                CFG_BOUNDS_ENABLE:  r_bounds_check_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req_type <= i_req_type;
            r_s1_start_x  <= i_start_x;
            r_s1_start_y  <= i_start_y;
            r_s1_end_x    <= i_end_x;
            r_s1_end_y    <= i_end_y;
        end
    end

    lps_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_fire                (s1_fire),
        .i_req_type            (r_s1_req_type),
        .i_start_x             (r_s1_start_x),
        .i_start_y             (r_s1_start_y),
        .i_end_x               (r_s1_end_x),
        .i_end_y               (r_s1_end_y),
        .i_row_stride          (r_row_stride),
        .i_surface_width       (r_surface_width),
        .i_surface_height      (r_surface_height),
        .i_bounds_check_enable (r_bounds_check_enable),
        .o_pixel_x             (res_pixel_x),
        .o_pixel_y             (res_pixel_y),
        .o_byte_offset         (res_byte_offset),
        .o_bit_mask            (res_bit_mask),
        .o_flags               (res_flags)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && res_flags.has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && res_flags.has_result) begin
            r_pixel_x     <= res_pixel_x;
            r_pixel_y     <= res_pixel_y;
            r_byte_offset <= res_byte_offset;
            r_bit_mask    <= res_bit_mask;
            r_last_pixel  <= res_flags.last_pixel;
            r_rejected    <= res_flags.rejected;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pixel_x;
    assign o_pixel_y     = r_pixel_y;
    assign o_byte_offset = r_byte_offset;
    assign o_bit_mask    = r_bit_mask;
    assign o_last_pixel  = r_last_pixel;
    assign o_rejected    = r_rejected;

endmodule

`default_nettype wire

// ===== src/lps_stepper.sv =====
// ----------------------------------------------------------------------------
// lps_stepper
// Bresenham line state: start loads or rejects, each active step emits a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_pixel_stepper_defines.svh"

module lps_stepper #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic                          i_req_type,
    input  wire logic [COORD_BITS-1:0]         i_start_x,
    input  wire logic [COORD_BITS-1:0]         i_start_y,
    input  wire logic [COORD_BITS-1:0]         i_end_x,
    input  wire logic [COORD_BITS-1:0]         i_end_y,
    input  wire logic [lps_pkg::STRIDE_W-1:0]  i_row_stride,
    input  wire logic [lps_pkg::SIZE_W-1:0]    i_surface_width,
    input  wire logic [lps_pkg::SIZE_W-1:0]    i_surface_height,
    input  wire logic                          i_bounds_check_enable,
    output logic [COORD_BITS-1:0]              o_pixel_x,
    output logic [COORD_BITS-1:0]              o_pixel_y,
    output logic [lps_pkg::OFFSET_W-1:0]       o_byte_offset,
    output logic [lps_pkg::MASK_W-1:0]         o_bit_mask,
    output lps_pkg::t_res_flags                o_flags
);
    import lps_pkg::*;

    localparam int TWICE_W = COORD_BITS + 1;
    localparam int ERR_W   = COORD_BITS + 3;
    localparam int CMP_W   = ((COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W) + 1;
    localparam int PROD_W  = COORD_BITS + STRIDE_W;
    localparam int MUL_W   = (PROD_W > OFFSET_W) ? PROD_W : OFFSET_W;

    logic                      r_active, n_active;
    logic [COORD_BITS-1:0]     r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0]     r_cur_y, n_cur_y;
    logic [OFFSET_W-1:0]       r_row_address, n_row_address;
    logic [COORD_BITS-1:0]     r_target_x, n_target_x;
    logic [COORD_BITS-1:0]     r_target_y, n_target_y;
    logic [TWICE_W-1:0]        r_twice_dx, n_twice_dx;
    logic [TWICE_W-1:0]        r_twice_dy, n_twice_dy;
    logic signed [ERR_W-1:0]   r_error_term, n_error_term;
    logic                      r_x_negative, n_x_negative;
    logic                      r_y_negative, n_y_negative;
    logic                      r_x_major, n_x_major;

    logic                      reject;
    logic                      st_x_neg, st_y_neg, st_x_major;
    logic [COORD_BITS-1:0]     abs_dx, abs_dy;
    logic [MUL_W-1:0]          row_product;
    logic                      err_ge;
    logic                      mv_x, mv_y;
    logic signed [ERR_W-1:0]   tdx_s, tdy_s;
    logic                      done;

    // An endpoint is outside when v >= size - 1, written as v + 1 >= size so
    // that a size of zero refuses everything.
    function automatic logic outside(input logic [COORD_BITS-1:0] v,
                                     input logic [SIZE_W-1:0] size);
        return (CMP_W'(v) + CMP_W'(1)) >= CMP_W'(size);
    endfunction

    always_comb begin
        reject = i_bounds_check_enable &&
                 (outside(i_start_x, i_surface_width) || outside(i_end_x, i_surface_width) ||
                  outside(i_start_y, i_surface_height) || outside(i_end_y, i_surface_height));
        st_x_neg   = i_end_x < i_start_x;
        st_y_neg   = i_end_y < i_start_y;
        abs_dx     = st_x_neg ? i_start_x - i_end_x : i_end_x - i_start_x;
        abs_dy     = st_y_neg ? i_start_y - i_end_y : i_end_y - i_start_y;
        st_x_major = abs_dx > abs_dy;
        row_product = MUL_W'(i_start_y) * MUL_W'(i_row_stride);

        tdx_s  = signed'(ERR_W'(r_twice_dx));
        tdy_s  = signed'(ERR_W'(r_twice_dy));
        err_ge = !r_error_term[ERR_W-1];
        mv_x   = r_x_major || err_ge;
        mv_y   = !r_x_major || err_ge;

        n_active      = r_active;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_row_address = r_row_address;
        n_target_x    = r_target_x;
        n_target_y    = r_target_y;
        n_twice_dx    = r_twice_dx;
        n_twice_dy    = r_twice_dy;
        n_error_term  = r_error_term;
        n_x_negative  = r_x_negative;
        n_y_negative  = r_y_negative;
        n_x_major     = r_x_major;
        done          = 1'b0;

        o_pixel_x     = '0;
        o_pixel_y     = '0;
        o_byte_offset = '0;
        o_bit_mask    = '0;
        o_flags       = '0;

        if (i_req_type == REQ_START) begin
            if (reject) begin
                n_active         = 1'b0;
                o_flags.has_result = 1'b1;
                o_flags.rejected = 1'b1;
            end else begin
                n_x_negative  = st_x_neg;
                n_y_negative  = st_y_neg;
                n_twice_dx    = {abs_dx, 1'b0};
                n_twice_dy    = {abs_dy, 1'b0};
                n_x_major     = st_x_major;
                // Initial error: twice the minor delta minus the major delta.
                n_error_term  = st_x_major ?
                    signed'(ERR_W'({abs_dy, 1'b0})) - signed'(ERR_W'(abs_dx)) :
                    signed'(ERR_W'({abs_dx, 1'b0})) - signed'(ERR_W'(abs_dy));
                n_cur_x       = i_start_x;
                n_cur_y       = i_start_y;
                n_target_x    = i_end_x;
                n_target_y    = i_end_y;
                n_row_address = row_product[OFFSET_W-1:0];
                n_active      = st_x_major ? (i_start_x != i_end_x) : (i_start_y != i_end_y);
            end
        end else if (r_active) begin
            if (mv_x) begin
                n_cur_x = r_x_negative ? r_cur_x - COORD_BITS'(1) : r_cur_x + COORD_BITS'(1);
            end
            if (mv_y) begin
                n_cur_y       = r_y_negative ? r_cur_y - COORD_BITS'(1)
                                             : r_cur_y + COORD_BITS'(1);
                n_row_address = r_y_negative ? r_row_address - OFFSET_W'(i_row_stride)
                                             : r_row_address + OFFSET_W'(i_row_stride);
            end
            if (r_x_major) begin
                n_error_term = r_error_term + tdy_s - (err_ge ? tdx_s : '0);
                done         = n_cur_x == r_target_x;
            end else begin
                n_error_term = r_error_term + tdx_s - (err_ge ? tdy_s : '0);
                done         = n_cur_y == r_target_y;
            end
            if (done) begin
                n_active = 1'b0;
            end
            o_flags.has_result = 1'b1;
            o_flags.last_pixel = done;
            o_pixel_x          = n_cur_x;
            o_pixel_y          = n_cur_y;
            o_byte_offset      = n_row_address + OFFSET_W'(n_cur_x >> 3);
            o_bit_mask         = LEFT_PIXEL_MASK >> n_cur_x[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_row_address <= n_row_address;
            r_target_x    <= n_target_x;
            r_target_y    <= n_target_y;
            r_twice_dx    <= n_twice_dx;
            r_twice_dy    <= n_twice_dy;
            r_error_term  <= n_error_term;
            r_x_negative  <= n_x_negative;
            r_y_negative  <= n_y_negative;
            r_x_major     <= n_x_major;
        end
    end

    `LPS_ASSERT_NOW(a_reject_clean, i_clk, i_rst_n, i_fire && o_flags.rejected,
        !o_flags.last_pixel && o_bit_mask == '0, "refused start carries pixel data")
    `LPS_ASSERT_NOW(a_mask_onehot, i_clk, i_rst_n,
        i_fire && o_flags.has_result && !o_flags.rejected, $onehot(o_bit_mask),
        "pixel mask is not one-hot")
    `LPS_ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n, i_fire && o_flags.last_pixel,
        !r_active, "line still active after its last pixel")
    `LPS_ASSERT_NOW(a_idle_step_silent, i_clk, i_rst_n,
        i_fire && i_req_type == REQ_STEP && !r_active, !o_flags.has_result,
        "step while idle produced a pixel")

endmodule

`default_nettype wire
